// ----- sv/dpe_pkg.sv -----
// dpe_pkg: shared types, constants and an arctangent table for the damped pendulum Euler step.
// Used by dpe_div and damped_pendulum_euler_step; no dependencies.
`default_nettype none
package dpe_pkg;
   localparam int FRAC_BITS_DEF    = 24;
   localparam int CORDIC_ITERS_DEF = 24;

   // register indexes
   localparam logic [2:0] REG_GRAVITY  = 3'd0;
   localparam logic [2:0] REG_LENGTH   = 3'd1;
   localparam logic [2:0] REG_DAMPING  = 3'd2;
   localparam logic [2:0] REG_DT       = 3'd3;
   localparam logic [2:0] REG_INIT_ANG = 3'd4;

   localparam logic signed [31:0] GRAVITY_RST  = -32'sd164584489;
   localparam logic [30:0]        LENGTH_RST   = 31'd16777216;
   localparam logic [30:0]        DAMPING_RST  = 31'd1677722;
   localparam logic [24:0]        DT_RST       = 25'd167772;
   localparam logic signed [31:0] INIT_ANG_RST = 32'sd13176795;

   localparam logic [63:0] PI60      = 64'h3243F6A8885A308D;
   localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;

   // arctangent table, Q30
   function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;  5'd2: v = 32'h0FADBAFC;
         5'd3: v = 32'h07F56EA6;  5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
         5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;  5'd8: v = 32'h003FFFEA;
         5'd9: v = 32'h001FFFFD;  5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF; 5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF; 5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF; 5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF; 5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F; 5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008; 5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001; default: v = 32'h00000000;
      endcase
      return {32'd0, v};
   endfunction

   // status from the divider to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

// ----- sv/dpe_mul.sv -----
// dpe_mul: shared signed 64 x 32 multiplier, two 32x32 partial products, low half then high half.
// Depends on nothing; used by damped_pendulum_euler_step.
`default_nettype none
module dpe_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] op_a,   // fits in 48 bits signed
   input  wire logic signed [31:0] op_b,
   output logic                    done,
   output logic signed [63:0]      prod
);
   logic [1:0]          phase_ff, phase_in;
   logic signed [63:0]  a_ff;
   logic signed [31:0]  b_ff;
   logic signed [63:0]  lo_ff;
   logic signed [63:0]  pp;
   logic signed [32:0]  part;

   // low half unsigned (zero-extended), high half signed
   always_comb begin
      if (phase_ff == 2'd1) part = {1'b0, a_ff[31:0]};
      else                  part = {a_ff[63], a_ff[63:32]};
      pp = 64'(part * b_ff);
   end

   always_comb begin
      phase_in = 2'd0;
      if (start) phase_in = 2'd1;
      else if (phase_ff == 2'd1) phase_in = 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
      end
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (phase_ff == 2'd1) lo_ff <= pp;
      if (phase_ff == 2'd2) prod <= lo_ff + (pp <<< 32);
   end

   always_ff @(posedge clock) begin
      if (reset) done <= 1'b0;
      else       done <= (phase_ff == 2'd2);
   end
endmodule
`default_nettype wire

// ----- sv/dpe_div.sv -----
// dpe_div: restoring divider, one quotient bit a cycle, quotient truncated toward zero.
// Depends on dpe_pkg; used by damped_pendulum_euler_step.
`default_nettype none
module dpe_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic [30:0]        divisor,
   output dpe_pkg::div_stat_type   stat,
   output logic signed [63:0]      quot
);
   logic [6:0]  cnt_ff;
   logic        done_ff;
   logic        neg_ff;
   logic [63:0] num_ff;
   logic [63:0] rem_ff;
   logic [30:0] den_ff;
   logic [63:0] trial;
   logic [63:0] mag;

   always_comb begin
      mag   = dividend[63] ? 64'(-dividend) : dividend;
      trial = {rem_ff[62:0], num_ff[63]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 7'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= 7'd64;
         end else if (cnt_ff != 7'd0) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) done_ff <= 1'b1;
         end
      end
      if (start) begin
         num_ff <= mag;
         rem_ff <= 64'd0;
         neg_ff <= dividend[63];
         den_ff <= (divisor == 31'd0) ? 31'd1 : divisor;
      end else if (cnt_ff != 7'd0) begin
         num_ff <= {num_ff[62:0], trial >= {33'd0, den_ff}};
         rem_ff <= (trial >= {33'd0, den_ff}) ? trial - {33'd0, den_ff} : trial;
      end
   end

   assign stat = '{busy: (cnt_ff != 7'd0), done: done_ff};
   assign quot = neg_ff ? 64'(-num_ff) : num_ff;
endmodule
`default_nettype wire

// ----- sv/damped_pendulum_euler_step.sv -----
// damped_pendulum_euler_step: top level, sequencer around the shared multiplier and divider.
// Depends on dpe_pkg, dpe_mul and dpe_div.
//
//  channel | ports                                       | direction
//  req     | req_valid, req_stall, req_advance           | in
//  rsp     | rsp_valid, rsp_stall, rsp_angle_out, ...    | out
//  csr     | csr_write, csr_index, csr_data              | in
//
// A report beat (advance low) passes from acceptance through ST_DONE and ST_RESP back to idle.
// In a step, the divider for gravity/length sets the pace and runs alongside the angle
// reduction and the CORDIC (one rotation a cycle, CORDIC_ITERS); its quotient is taken
// once the divider is neither busy nor flagging done, then five products run on the shared
// multiplier and ST_DONE and ST_RESP hand the result over; rsp_stall holds it in ST_RESP.
// Reset is synchronous; the state then holds initial_angle and zero velocity.
// req_stall is high while a beat is being worked or its result waits; rsp_valid holds under
// rsp_stall.
`default_nettype none
module damped_pendulum_euler_step #(
   parameter int FRAC_BITS    = dpe_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_ITERS = dpe_pkg::CORDIC_ITERS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_advance,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_angle_out,
   output logic signed [31:0]      rsp_velocity_out,
   output logic                    rsp_overflow,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [63:0] PI_F =
      64'((dpe_pkg::PI60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
   localparam logic signed [63:0] TWO_PI = 2 * PI_F;
   localparam logic signed [63:0] HALF_PI = PI_F / 2;
   localparam logic signed [63:0] I32MAX = 64'sd2147483647;
   localparam logic signed [63:0] I32MIN = -64'sd2147483648;
   localparam logic signed [63:0] WLIM = (64'sd1 <<< 37) - 64'sd1;
   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
   // compare-subtract steps that bring any 32-bit angle below one turn
   localparam int RED_STEPS = (FRAC_BITS < 29) ? 29 - FRAC_BITS : 0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MOD, ST_REDUCE, ST_FOLD, ST_CORDIC, ST_WAITDIV,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_DONE, ST_RESP
   } state_type;

   // configuration
   logic signed [31:0] gravity_ff;
   logic [30:0]        length_ff;
   logic [30:0]        damping_ff;
   logic [24:0]        dt_ff;
   logic signed [31:0] angle_ff, vel_ff;

   state_type          state_ff;
   logic               mul_go_ff;
   logic signed [63:0] r_ff, x_ff, y_ff, z_ff;
   logic [4:0]         it_ff;
   logic [4:0]         red_ff;
   logic               aneg_ff;
   logic signed [63:0] q_ff, s_ff, acc_ff, v_ff;
   logic               ovf_ff;

   logic               mul_start, mul_done;
   logic signed [63:0] mul_a, prod;
   logic signed [31:0] mul_b;
   logic               div_start;
   dpe_pkg::div_stat_type div_stat;
   logic signed [63:0] quot;

   // rounding shift, ties toward +inf
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
      return (v + HALF_LSB) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   dpe_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .prod(prod)
   );

   dpe_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(64'(-64'(gravity_ff)) <<< FRAC_BITS), .divisor(length_ff),
      .stat(div_stat), .quot(quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign div_start = (state_ff == ST_IDLE) && req_valid && req_advance;
   assign mul_start = mul_go_ff;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = 64'sd0;
      mul_b = 32'sd0;
      case (state_ff)
         ST_M1: begin mul_a = q_ff; mul_b = s_ff[31:0]; end
         ST_M2: begin mul_a = acc_ff; mul_b = {7'd0, dt_ff}; end
         ST_M3: begin mul_a = 64'(vel_ff); mul_b = {1'b0, damping_ff}; end
         ST_M4: begin mul_a = acc_ff; mul_b = {7'd0, dt_ff}; end
         ST_M5: begin mul_a = v_ff; mul_b = {7'd0, dt_ff}; end
         default: begin mul_a = 64'sd0; mul_b = 32'sd0; end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      logic signed [63:0] t;
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_go_ff  <= 1'b0;
         rsp_valid  <= 1'b0;
         gravity_ff <= dpe_pkg::GRAVITY_RST;
         length_ff  <= dpe_pkg::LENGTH_RST;
         damping_ff <= dpe_pkg::DAMPING_RST;
         dt_ff      <= dpe_pkg::DT_RST;
         angle_ff   <= dpe_pkg::INIT_ANG_RST;
         vel_ff     <= 32'sd0;
      end else begin
         mul_go_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               dpe_pkg::REG_GRAVITY:  gravity_ff <= csr_data;
               dpe_pkg::REG_LENGTH:   length_ff  <= csr_data[30:0];
               dpe_pkg::REG_DAMPING:  damping_ff <= csr_data[30:0];
               dpe_pkg::REG_DT:       dt_ff      <= csr_data[24:0];
               dpe_pkg::REG_INIT_ANG: begin
                  angle_ff <= csr_data;
                  vel_ff   <= 32'sd0;
               end
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: if (req_valid) begin
               ovf_ff  <= 1'b0;
               r_ff    <= angle_ff[31] ? -64'(angle_ff) : 64'(angle_ff);
               aneg_ff <= angle_ff[31];
               red_ff  <= 5'(RED_STEPS);
               state_ff <= req_advance ? ST_MOD : ST_DONE;
            end
            // remainder of |angle| by one turn, one compare-subtract a cycle, then the sign restored
            ST_MOD: begin
               if (red_ff == 5'd0) begin
                  r_ff     <= aneg_ff ? -r_ff : r_ff;
                  state_ff <= ST_REDUCE;
               end else begin
                  if (r_ff >= (TWO_PI <<< (red_ff - 5'd1)))
                     r_ff <= r_ff - (TWO_PI <<< (red_ff - 5'd1));
                  red_ff <= red_ff - 5'd1;
               end
            end
            ST_REDUCE: begin
               t = (r_ff < 0) ? r_ff + TWO_PI : r_ff;
               r_ff <= (t >= PI_F) ? t - TWO_PI : t;
               state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               if (r_ff > HALF_PI)       t = PI_F - r_ff;
               else if (r_ff < -HALF_PI) t = -PI_F - r_ff;
               else                      t = r_ff;
               z_ff  <= t <<< SH;
               x_ff  <= dpe_pkg::CORDIC_GAIN;
               y_ff  <= 64'sd0;
               it_ff <= 5'd0;
               state_ff <= ST_CORDIC;
            end
            ST_CORDIC: begin
               if (z_ff >= 0) begin
                  x_ff <= x_ff - (y_ff >>> it_ff);
                  y_ff <= y_ff + (x_ff >>> it_ff);
                  z_ff <= z_ff - dpe_pkg::atan_q30(it_ff);
               end else begin
                  x_ff <= x_ff + (y_ff >>> it_ff);
                  y_ff <= y_ff - (x_ff >>> it_ff);
                  z_ff <= z_ff + dpe_pkg::atan_q30(it_ff);
               end
               it_ff <= it_ff + 5'd1;
               if (32'(it_ff) == CORDIC_ITERS - 1) state_ff <= ST_WAITDIV;
            end
            ST_WAITDIV: begin
               if (SH == 0) s_ff <= y_ff;
               else s_ff <= (y_ff + (64'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
               if (!div_stat.busy && !div_stat.done) begin
                  q_ff      <= clamp(quot, I32MIN, I32MAX);
                  mul_go_ff <= 1'b1;
                  state_ff  <= ST_M1;
               end
            end
            ST_M1: if (mul_done) begin
               acc_ff <= rnd(prod); mul_go_ff <= 1'b1; state_ff <= ST_M2;
            end
            ST_M2: if (mul_done) begin
               v_ff <= 64'(vel_ff) + rnd(prod); mul_go_ff <= 1'b1; state_ff <= ST_M3;
            end
            ST_M3: if (mul_done) begin
               acc_ff <= clamp(rnd(prod), -WLIM, WLIM); mul_go_ff <= 1'b1; state_ff <= ST_M4;
            end
            ST_M4: if (mul_done) begin
               t = v_ff - rnd(prod);
               v_ff   <= clamp(t, I32MIN, I32MAX);
               ovf_ff <= (t > I32MAX) || (t < I32MIN);
               mul_go_ff <= 1'b1;
               state_ff <= ST_M5;
            end
            ST_M5: if (mul_done) begin
               t = 64'(angle_ff) + rnd(prod);
               angle_ff <= 32'(clamp(t, I32MIN, I32MAX));
               vel_ff   <= v_ff[31:0];
               ovf_ff   <= ovf_ff || (t > I32MAX) || (t < I32MIN);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid        <= 1'b1;
               rsp_angle_out    <= angle_ff;
               rsp_velocity_out <= vel_ff;
               rsp_overflow     <= ovf_ff;
               state_ff         <= ST_RESP;
            end
            ST_RESP: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a result beat is only offered while the sequencer waits for it to go
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_RESP)
      else $error("result beat outside response state");
   // no new request is taken while a result is pending
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with result pending");
   // a report beat never flags overflow
   a_report_ovf: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && !req_advance) |=> !ovf_ff)
      else $error("overflow on report beat");
endmodule
`default_nettype wire
